// File: design/abcdq_pkg.sv
// Shared constants, pipeline control type and sine table generator for the abc to dq0 transform.
package abcdq_pkg;

    // Number of register stages from input to output register.
    localparam int NUM_STAGES = 5;

    // Signed sine/cosine width; the table spans 0 to +32768 inclusive.
    localparam int TRIG_W = 18;
    localparam int ROM_W  = 17;

    // 1/sqrt(3) in Q16, kept as a positive signed operand.
    localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;

    // Fixed-point constants for building the sine table at elaboration.
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TRIG_ONE    = 64'd32768;
    localparam logic [7:0]  TAYLOR_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    // Per-stage advance enables plus the configured sensor mode.
    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
        logic                  sensor_mode;
    } pipe_ctrl_t;

    // One quarter-wave sine entry, Q30 Taylor series evaluated in Horner form.
    function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] k,
                                                    input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        int          i;
        x  = (k * HALF_PI_Q30 + (64'd1 << (tbits - 1))) >> tbits;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = Q30_ONE;
        for (i = 0; i < 6; i++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(TAYLOR_DIV[i]));
        end
        t = (x * t) >> 30;
        return ROM_W'((t * TRIG_ONE + (64'd1 << 29)) >> 30);
    endfunction

endpackage

// File: design/abcdq_clarke.sv
// Three-stage Clarke transform: sums, constant multiplies, divide-by-three correction.
module abcdq_clarke #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         aclk,
    input  abcdq_pkg::pipe_ctrl_t        ctrl,
    input  logic signed [SAMPLE_BITS-1:0] phase_a,
    input  logic signed [SAMPLE_BITS-1:0] phase_b,
    input  logic signed [SAMPLE_BITS-1:0] phase_c,
    output logic signed [SAMPLE_BITS:0]   alpha,
    output logic signed [SAMPLE_BITS:0]   beta,
    output logic signed [SAMPLE_BITS-1:0] zero_seq
);

    // Working widths: signed sums, offset numerators, beta operand and product.
    localparam int DW = SAMPLE_BITS + 5;
    localparam int MW = SAMPLE_BITS + 4;
    localparam int BW = SAMPLE_BITS + 2;
    localparam int PW = SAMPLE_BITS + 20;

    // The offset 3*2^(S+2) makes every numerator positive and is a multiple of three.
    localparam logic signed [DW-1:0] DIV_OFFSET = {3'b011, {(SAMPLE_BITS + 2){1'b0}}};
    // Truncated reciprocal of three; the quotient from it is low by at most one.
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << MW) / 64'd3);
    localparam logic signed [PW-1:0] ROUND_Q16 = PW'(32768);

    logic signed [DW-1:0] a_w;
    logic signed [DW-1:0] b_w;
    logic signed [DW-1:0] c_w;
    logic signed [DW-1:0] alpha_num;
    logic signed [DW-1:0] zero_num;
    logic signed [DW-1:0] alpha_off;
    logic signed [DW-1:0] zero_off;
    logic signed [BW-1:0] beta_x;

    logic [MW-1:0]        s1_alpha_m_reg;
    logic [MW-1:0]        s1_zero_m_reg;
    logic signed [BW-1:0] s1_beta_x_reg;

    logic [2*MW-1:0]      alpha_prod;
    logic [2*MW-1:0]      zero_prod;
    logic signed [PW-1:0] beta_prod;

    logic [MW-1:0]        s2_alpha_m_reg;
    logic [MW-1:0]        s2_zero_m_reg;
    logic [MW-1:0]        s2_alpha_q0_reg;
    logic [MW-1:0]        s2_zero_q0_reg;
    logic signed [PW-1:0] s2_beta_prod_reg;

    logic [MW-1:0]        alpha_rem;
    logic [MW-1:0]        zero_rem;
    logic [MW-1:0]        alpha_q;
    logic [MW-1:0]        zero_q;

    logic signed [SAMPLE_BITS:0]   s3_alpha_reg;
    logic signed [SAMPLE_BITS:0]   s3_beta_reg;
    logic signed [SAMPLE_BITS-1:0] s3_zero_reg;

    // Stage 1: numerators. The alpha and zero results are floor((n+1)/3); in
    // two-sensor mode alpha's numerator is 3a so that the same divider returns a.
    always_comb begin
        a_w = DW'(phase_a);
        b_w = DW'(phase_b);
        c_w = DW'(phase_c);
        if (ctrl.sensor_mode) begin
            alpha_num = (a_w <<< 1) - b_w - c_w + DW'(1);
            zero_num  = a_w + b_w + c_w + DW'(1);
            beta_x    = BW'(phase_b) - BW'(phase_c);
        end else begin
            alpha_num = (a_w <<< 1) + a_w;
            zero_num  = '0;
            beta_x    = BW'(phase_a) + (BW'(phase_b) <<< 1);
        end
        alpha_off = alpha_num + DIV_OFFSET;
        zero_off  = zero_num + DIV_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[0]) begin
            s1_alpha_m_reg <= alpha_off[MW-1:0];
            s1_zero_m_reg  <= zero_off[MW-1:0];
            s1_beta_x_reg  <= beta_x;
        end
    end

    // Stage 2: reciprocal multiplies and the rounded 1/sqrt(3) product.
    always_comb begin
        alpha_prod = (2*MW)'(s1_alpha_m_reg) * (2*MW)'(RECIP);
        zero_prod  = (2*MW)'(s1_zero_m_reg) * (2*MW)'(RECIP);
        beta_prod  = PW'(s1_beta_x_reg) * PW'(abcdq_pkg::INV_SQRT3_Q16) + ROUND_Q16;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[1]) begin
            s2_alpha_m_reg   <= s1_alpha_m_reg;
            s2_zero_m_reg    <= s1_zero_m_reg;
            s2_alpha_q0_reg  <= alpha_prod[2*MW-1:MW];
            s2_zero_q0_reg   <= zero_prod[2*MW-1:MW];
            s2_beta_prod_reg <= beta_prod;
        end
    end

    // Stage 3: bump the estimated quotient when the remainder reaches three.
    always_comb begin
        alpha_rem = s2_alpha_m_reg - (s2_alpha_q0_reg << 1) - s2_alpha_q0_reg;
        zero_rem  = s2_zero_m_reg - (s2_zero_q0_reg << 1) - s2_zero_q0_reg;
        alpha_q   = (alpha_rem >= MW'(3)) ? s2_alpha_q0_reg + MW'(1) : s2_alpha_q0_reg;
        zero_q    = (zero_rem >= MW'(3)) ? s2_zero_q0_reg + MW'(1) : s2_zero_q0_reg;
    end

    // Removing the offset's quotient 2^(S+2) leaves the low bits unchanged, and
    // both results fit their widths, so the low bits are the answer.
    always_ff @(posedge aclk) begin
        if (ctrl.adv[2]) begin
            s3_alpha_reg <= alpha_q[SAMPLE_BITS:0];
            s3_zero_reg  <= zero_q[SAMPLE_BITS-1:0];
            s3_beta_reg  <= s2_beta_prod_reg[SAMPLE_BITS+16:16];
        end
    end

    assign alpha    = s3_alpha_reg;
    assign beta     = s3_beta_reg;
    assign zero_seq = s3_zero_reg;

endmodule

// File: design/abcdq_sincos.sv
// Three-stage sine/cosine lookup from a quarter-wave table with quadrant folding.
module abcdq_sincos #(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 aclk,
    input  abcdq_pkg::pipe_ctrl_t                ctrl,
    input  logic [ANGLE_BITS-1:0]                angle,
    output logic signed [abcdq_pkg::TRIG_W-1:0]  sin_val,
    output logic signed [abcdq_pkg::TRIG_W-1:0]  cos_val
);

    localparam int RBITS = ANGLE_BITS - 2;
    localparam int N     = 1 << SINE_TABLE_BITS;
    localparam int AW    = SINE_TABLE_BITS + 1;
    localparam int TW    = abcdq_pkg::TRIG_W;

    typedef logic [abcdq_pkg::ROM_W-1:0] rom_t [0:N];

    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quadrant_t;

    // Quarter-wave table, entries 0 through N inclusive.
    function automatic rom_t build_rom();
        rom_t r;
        int   k;
        for (k = 0; k <= N; k++) begin
            r[k] = abcdq_pkg::sine_entry(64'(k), SINE_TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [SINE_TABLE_BITS-1:0]    idx;
    logic [SINE_TABLE_BITS-1:0]    s1_idx_reg;
    quadrant_t                     s1_quad_reg;
    logic [AW-1:0]                 addr_lo;
    logic [AW-1:0]                 addr_hi;
    logic [abcdq_pkg::ROM_W-1:0]   s2_lo_reg;
    logic [abcdq_pkg::ROM_W-1:0]   s2_hi_reg;
    quadrant_t                     s2_quad_reg;
    logic signed [TW-1:0]          lo_s;
    logic signed [TW-1:0]          hi_s;
    logic signed [TW-1:0]          sin_next;
    logic signed [TW-1:0]          cos_next;
    logic signed [TW-1:0]          sin_reg;
    logic signed [TW-1:0]          cos_reg;

    // Table index from the bits below the quadrant, truncated or zero padded.
    generate
        if (RBITS >= SINE_TABLE_BITS) begin : g_idx_trunc
            assign idx = angle[RBITS-1 -: SINE_TABLE_BITS];
        end else begin : g_idx_pad
            assign idx = {angle[RBITS-1:0], {(SINE_TABLE_BITS - RBITS){1'b0}}};
        end
    endgenerate

    // Stage 1: register index and quadrant.
    always_ff @(posedge aclk) begin
        if (ctrl.adv[0]) begin
            s1_idx_reg  <= idx;
            s1_quad_reg <= quadrant_t'(angle[ANGLE_BITS-1 -: 2]);
        end
    end

    // Stage 2: two table reads, at the index and at its complement.
    assign addr_lo = {1'b0, s1_idx_reg};
    assign addr_hi = AW'(N) - addr_lo;

    always_ff @(posedge aclk) begin
        if (ctrl.adv[1]) begin
            s2_lo_reg   <= SINE_ROM[addr_lo];
            s2_hi_reg   <= SINE_ROM[addr_hi];
            s2_quad_reg <= s1_quad_reg;
        end
    end

    // Stage 3: fold the quarter wave into the full circle.
    always_comb begin
        lo_s = TW'(s2_lo_reg);
        hi_s = TW'(s2_hi_reg);
        unique case (s2_quad_reg)
            QUAD_FIRST: begin
                sin_next = lo_s;
                cos_next = hi_s;
            end
            QUAD_SECOND: begin
                sin_next = hi_s;
                cos_next = -lo_s;
            end
            QUAD_THIRD: begin
                sin_next = -lo_s;
                cos_next = -hi_s;
            end
            QUAD_FOURTH: begin
                sin_next = -hi_s;
                cos_next = lo_s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[2]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: design/abcdq_park.sv
// Two-stage Park rotation: four products, then rounded sums with saturation.
module abcdq_park #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  abcdq_pkg::pipe_ctrl_t               ctrl,
    input  logic signed [SAMPLE_BITS:0]         alpha,
    input  logic signed [SAMPLE_BITS:0]         beta,
    input  logic signed [SAMPLE_BITS-1:0]       zero_in,
    input  logic signed [abcdq_pkg::TRIG_W-1:0] sin_val,
    input  logic signed [abcdq_pkg::TRIG_W-1:0] cos_val,
    output logic signed [SAMPLE_BITS+1:0]       d_axis,
    output logic signed [SAMPLE_BITS+1:0]       q_axis,
    output logic signed [SAMPLE_BITS-1:0]       zero_seq
);

    localparam int PW  = SAMPLE_BITS + 19;
    localparam int SW  = SAMPLE_BITS + 20;
    localparam int RW  = SAMPLE_BITS + 5;
    localparam int DQW = SAMPLE_BITS + 2;

    localparam logic signed [SW-1:0] ROUND_Q15 = SW'(16384);
    localparam logic signed [RW-1:0] DQ_MAX = {4'b0000, {(SAMPLE_BITS + 1){1'b1}}};
    localparam logic signed [RW-1:0] DQ_MIN = {4'b1111, {(SAMPLE_BITS + 1){1'b0}}};

    logic signed [PW-1:0]          s4_ac_reg;
    logic signed [PW-1:0]          s4_bs_reg;
    logic signed [PW-1:0]          s4_bc_reg;
    logic signed [PW-1:0]          s4_as_reg;
    logic signed [SAMPLE_BITS-1:0] s4_zero_reg;

    logic signed [SW-1:0]          d_sum;
    logic signed [SW-1:0]          q_sum;
    logic signed [RW-1:0]          d_shift;
    logic signed [RW-1:0]          q_shift;
    logic signed [DQW-1:0]         d_next;
    logic signed [DQW-1:0]         q_next;

    logic signed [DQW-1:0]         d_reg;
    logic signed [DQW-1:0]         q_reg;
    logic signed [SAMPLE_BITS-1:0] zero_reg;

    // Clamp a shifted sum to the output range.
    function automatic logic signed [DQW-1:0] sat_dq(input logic signed [RW-1:0] v);
        logic signed [DQW-1:0] r;
        if (v > DQ_MAX) begin
            r = DQ_MAX[DQW-1:0];
        end else if (v < DQ_MIN) begin
            r = DQ_MIN[DQW-1:0];
        end else begin
            r = v[DQW-1:0];
        end
        return r;
    endfunction

    // Stage 4: the four rotation products.
    always_ff @(posedge aclk) begin
        if (ctrl.adv[3]) begin
            s4_ac_reg   <= PW'(alpha) * PW'(cos_val);
            s4_bs_reg   <= PW'(beta) * PW'(sin_val);
            s4_bc_reg   <= PW'(beta) * PW'(cos_val);
            s4_as_reg   <= PW'(alpha) * PW'(sin_val);
            s4_zero_reg <= zero_in;
        end
    end

    // Stage 5: round half up at bit 15, then saturate.
    always_comb begin
        d_sum   = SW'(s4_ac_reg) + SW'(s4_bs_reg) + ROUND_Q15;
        q_sum   = SW'(s4_bc_reg) - SW'(s4_as_reg) + ROUND_Q15;
        d_shift = d_sum[SW-1:15];
        q_shift = q_sum[SW-1:15];
        d_next  = sat_dq(d_shift);
        q_next  = sat_dq(q_shift);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[4]) begin
            d_reg    <= d_next;
            q_reg    <= q_next;
            zero_reg <= s4_zero_reg;
        end
    end

    assign d_axis   = d_reg;
    assign q_axis   = q_reg;
    assign zero_seq = zero_reg;

endmodule

// File: design/abc_to_dq0_transform_unit.sv
// Top level of the abc to dq0 transform: stage valids, flow control and mode register.
//
// Usage: each transaction on the s_ channel carries three signed phase samples and an
// electrical angle (full scale equals two pi). Each produces exactly one transaction
// on the m_ channel with the saturated d and q components and the zero sequence.
// Transactions leave in the order they were accepted.
// A transaction passes from acceptance to m_valid through five register stages:
// numerator sums, constant and reciprocal multiplies, divide-by-three correction
// with sine/cosine folding, the rotation products, and rounding with saturation
// into the output register.
// Throughput is one transaction per cycle; a new transaction can be accepted in every
// cycle in which the pipeline is moving.
// When m_ready is low, the output register holds its transaction and the stages
// behind it keep filling empty slots; s_ready falls only once every stage is full.
// The cfg_we/cfg_wdata port writes sensor_mode (1 = three sensors, 0 = two sensors);
// write it only while no transaction is in flight.
// Synchronous active-low reset empties every stage and sets three-sensor mode.
module abc_to_dq0_transform_unit #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_phase_a,
    input  logic signed [SAMPLE_BITS-1:0] s_phase_b,
    input  logic signed [SAMPLE_BITS-1:0] s_phase_c,
    input  logic [ANGLE_BITS-1:0]         s_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS+1:0] m_d_axis,
    output logic signed [SAMPLE_BITS+1:0] m_q_axis,
    output logic signed [SAMPLE_BITS-1:0] m_zero_seq
);

    localparam int NS = abcdq_pkg::NUM_STAGES;

    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   valid_next;
    logic [NS-1:0]   valid_shift;
    logic [NS-1:0]   stage_en;
    logic            sensor_mode_reg;
    abcdq_pkg::pipe_ctrl_t ctrl;

    logic signed [SAMPLE_BITS:0]           alpha;
    logic signed [SAMPLE_BITS:0]           beta;
    logic signed [SAMPLE_BITS-1:0]         zero_c;
    logic signed [abcdq_pkg::TRIG_W-1:0]   sin_val;
    logic signed [abcdq_pkg::TRIG_W-1:0]   cos_val;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb begin
        valid_shift = {valid_reg[NS-2:0], s_valid};
        for (int k = 0; k < NS; k++) begin
            valid_next[k] = stage_en[k] ? valid_shift[k] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            sensor_mode_reg <= 1'b1;
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                sensor_mode_reg <= cfg_wdata;
            end
        end
    end

    assign ctrl.adv         = stage_en;
    assign ctrl.sensor_mode = sensor_mode_reg;
    assign s_ready          = stage_en[0];
    assign m_valid          = valid_reg[NS-1];

    // Stationary-frame components, stages 1 to 3.
    abcdq_clarke #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_clarke (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .phase_a (s_phase_a),
        .phase_b (s_phase_b),
        .phase_c (s_phase_c),
        .alpha   (alpha),
        .beta    (beta),
        .zero_seq(zero_c)
    );

    // Sine and cosine of the angle, stages 1 to 3.
    abcdq_sincos #(
        .ANGLE_BITS     (ANGLE_BITS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_sincos (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .angle  (s_angle),
        .sin_val(sin_val),
        .cos_val(cos_val)
    );

    // Rotation into the dq frame, stages 4 and 5.
    abcdq_park #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_park (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .alpha   (alpha),
        .beta    (beta),
        .zero_in (zero_c),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .d_axis  (m_d_axis),
        .q_axis  (m_q_axis),
        .zero_seq(m_zero_seq)
    );

endmodule

// File: design/abcdq_checker.sv
// Port-level assertions for the abc to dq0 transform, bound to the top level.
module abcdq_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS+1:0] m_d_axis,
    input logic signed [SAMPLE_BITS+1:0] m_q_axis,
    input logic signed [SAMPLE_BITS-1:0] m_zero_seq
);

    // A stalled result transaction stays valid and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_d_axis) && $stable(m_q_axis)
                                && $stable(m_zero_seq))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the output register empty every stage can move, so input is taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output register empty");

    // An accepted transaction reaches the output when m_ready keeps the pipeline from stalling.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

endmodule

bind abc_to_dq0_transform_unit abcdq_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_abcdq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_d_axis  (m_d_axis),
    .m_q_axis  (m_q_axis),
    .m_zero_seq(m_zero_seq)
);
